### rtl/core/bga_pkg.sv
// Package: shared constants, payload types and command codes of the adjacency table.
package bga_pkg;

  localparam int Vertices  = 64;
  localparam int EdgeSlots = 8;
  localparam int VW        = $clog2(Vertices);
  localparam int SW        = $clog2(EdgeSlots);
  localparam int CW        = $clog2(EdgeSlots + 1);
  localparam int SlotWords = Vertices * EdgeSlots;
  localparam int AW        = $clog2(SlotWords);
  // slot word: valid bit plus target index
  localparam int EW        = 1 + 7;

  typedef enum logic [2:0] {
    CMD_ADD_VERTEX = 3'd0,
    CMD_REM_VERTEX = 3'd1,
    CMD_ADD_EDGE   = 3'd2,
    CMD_REM_EDGE   = 3'd3,
    CMD_CONNECTED  = 3'd4,
    CMD_NEXT_NBR   = 3'd5,
    CMD_EDGE_COUNT = 3'd6,
    CMD_EXISTS     = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_INCONS  = 3'd4;

  localparam logic [3:0] SLOTS_RESET = 4'd8;
  localparam int         REG_SLOTS   = 0;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] from_vertex;
    logic [6:0] to_vertex;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [5:0] result_vertex;
    logic [3:0] edge_count;
  } rsp_t;

endpackage

### rtl/core/bga_ram.sv
// Generic single-port RAM with registered read.
module bga_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/core/bga_seq.sv
// Command sequencer: walks the slot memory word by word as needed; a new command is taken only in idle.
module bga_seq import bga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  input  logic [3:0] slots_cfg,
  output logic       busy,
  output logic       done,
  output rsp_t       rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DECIDE, S_FIND, S_OWN, S_SCAN_RD, S_SCAN_CHK,
    S_SLOT_RD, S_SLOT_CHK, S_DONE
  } state_t;

  state_t state;
  req_t   cur;
  logic [VW-1:0] vpos;     // vertex walker
  logic [SW-1:0] spos;     // slot walker
  logic [SW:0]   steps;    // slots visited in the per-vertex walk
  logic [VW:0]   vsteps;   // vertices tried in the free search
  logic [VW-1:0] free_ptr;
  logic [SW-1:0] rot_ptr;
  logic [Vertices-1:0] present;
  logic [CW-1:0] fcnt;     // working count of the subject vertex
  logic [CW-1:0] vcnt;     // running count of the scanned vertex
  logic          reg_found;
  logic [2:0]    reg_status;
  logic [5:0]    reg_rv;
  logic [VW:0]   clr;

  // slot memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  bga_ram #(.Width(EW), .Depth(SlotWords)) u_slots (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // neighbour count memory port
  logic          cnt_we;
  logic [VW-1:0] cnt_addr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;

  bga_ram #(.Width(CW), .Depth(Vertices)) u_counts (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  // clamp slots in use to 1..EdgeSlots
  logic [SW:0] kk;
  always_comb begin
    if (slots_cfg == 4'd0) kk = (SW+1)'(1);
    else if (32'(slots_cfg) > EdgeSlots) kk = (SW+1)'(EdgeSlots);
    else kk = (SW+1)'(slots_cfg);
  end

  logic f_ok, t_ok;
  logic [VW-1:0] fv, tv;
  assign f_ok = 32'(cur.from_vertex) < Vertices;
  assign t_ok = 32'(cur.to_vertex) < Vertices;
  assign fv   = cur.from_vertex[VW-1:0];
  assign tv   = cur.to_vertex[VW-1:0];

  logic hit_t;
  assign hit_t = ram_rdata[EW-1] && (ram_rdata[6:0] == cur.to_vertex);
  logic hit_f;
  assign hit_f = ram_rdata[EW-1] && (ram_rdata[6:0] == 7'(fv));

  logic [SW-1:0] spos_last;
  assign spos_last = SW'(EdgeSlots - 1);

  // count of the scanned vertex: fresh read on its first slot, running value after
  logic [CW-1:0] v_base, v_next;
  assign v_base = (spos == '0) ? cnt_rdata : vcnt;
  assign v_next = (hit_f && v_base != '0) ? v_base - CW'(1) : v_base;

  logic [SW-1:0] rot_nxt;
  assign rot_nxt = ((32'(rot_ptr) + 1) >= 32'(kk)) ? '0 : rot_ptr + SW'(1);

  // memory address and write for the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = AW'({vpos, spos});
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = AW'({clr[VW-1:0], {SW{1'b0}}}) | AW'(spos);
      end
      S_OWN: begin
        ram_we   = 1'b1;
        ram_addr = AW'({fv, spos});
      end
      S_SCAN_CHK: begin
        ram_we = hit_f;
      end
      S_SLOT_CHK: begin
        if (cur.command == CMD_ADD_EDGE && !ram_rdata[EW-1]) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, cur.to_vertex};
        end else if (cur.command == CMD_REM_EDGE && hit_t) begin
          ram_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // count memory: clear after reset, read subject on accept, write during scan and back at the end
  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    cnt_addr  = fv;
    unique case (state)
      S_CLEAR: begin
        cnt_we   = 1'b1;
        cnt_addr = clr[VW-1:0];
      end
      S_IDLE: begin
        cnt_addr = req.from_vertex[VW-1:0];
      end
      S_SCAN_RD: begin
        cnt_addr = vpos;
      end
      S_SCAN_CHK: begin
        cnt_addr  = vpos;
        cnt_we    = (spos == spos_last);
        cnt_wdata = v_next;
      end
      S_DONE: begin
        cnt_we    = 1'b1;
        cnt_wdata = fcnt;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign rsp.status        = reg_status;
  assign rsp.found         = reg_found;
  assign rsp.result_vertex = reg_rv;
  assign rsp.edge_count    = f_ok ? 4'(fcnt) : 4'd0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      spos      <= '0;
      present   <= '0;
      free_ptr  <= '0;
      rot_ptr   <= SW'(EdgeSlots - 1);
    end else begin
      unique case (state)
        // sweep the slot and count memories after reset
        S_CLEAR: begin
          spos <= spos + SW'(1);
          if (spos == spos_last) begin
            clr <= clr + 1'b1;
            if (32'(clr) == Vertices - 1) begin
              state <= S_IDLE;
              spos  <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            cur   <= req;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          reg_status <= ST_OK;
          reg_found  <= 1'b0;
          reg_rv     <= '0;
          spos       <= '0;
          steps      <= '0;
          vpos       <= '0;
          state      <= S_DONE;
          fcnt       <= (cur.command == CMD_REM_VERTEX && f_ok && present[fv]) ?
                        '0 : cnt_rdata;
          unique case (cmd_t'(cur.command))
            CMD_ADD_VERTEX: begin
              vpos   <= free_ptr;
              vsteps <= '0;
              state  <= S_FIND;
            end
            CMD_REM_VERTEX: begin
              if (!f_ok) reg_status <= ST_RANGE;
              else if (!present[fv]) reg_status <= ST_MISSING;
              else begin
                present[fv] <= 1'b0;
                if (fv < free_ptr) free_ptr <= fv;
                state <= S_OWN;
              end
            end
            CMD_ADD_EDGE, CMD_REM_EDGE, CMD_CONNECTED: begin
              if (!f_ok || !t_ok) reg_status <= ST_RANGE;
              else if (!present[fv] || !present[tv]) reg_status <= ST_MISSING;
              else begin
                vpos <= fv;
                if (cur.command == CMD_ADD_EDGE) reg_status <= ST_FULL;
                state <= S_SLOT_RD;
              end
            end
            CMD_NEXT_NBR: begin
              if (!f_ok) reg_status <= ST_RANGE;
              else if (cnt_rdata != '0) begin
                reg_status <= ST_INCONS;
                vpos       <= fv;
                spos       <= rot_nxt;
                rot_ptr    <= rot_nxt;
                state      <= S_SLOT_RD;
              end
            end
            CMD_EDGE_COUNT: begin
              if (!f_ok) reg_status <= ST_RANGE;
            end
            CMD_EXISTS: begin
              if (!f_ok) reg_status <= ST_RANGE;
              else reg_found <= present[fv];
            end
            default: ;
          endcase
        end
        // one vertex a cycle from the search pointer
        S_FIND: begin
          if (!present[vpos]) begin
            present[vpos] <= 1'b1;
            free_ptr      <= vpos;
            reg_rv        <= 6'(vpos);
            state         <= S_DONE;
          end else if (32'(vsteps) == Vertices - 1) begin
            reg_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            vsteps <= vsteps + 1'b1;
            vpos   <= (32'(vpos) == Vertices - 1) ? '0 : vpos + VW'(1);
          end
        end
        // drop every outgoing slot of the removed vertex
        S_OWN: begin
          spos <= spos + SW'(1);
          if (spos == spos_last) begin
            spos  <= '0;
            vpos  <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        // drop incoming edges, one slot word per read
        S_SCAN_CHK: begin
          vcnt  <= v_next;
          state <= S_SCAN_RD;
          spos  <= spos + SW'(1);
          if (spos == spos_last) begin
            vpos <= vpos + VW'(1);
            if (32'(vpos) == Vertices - 1) state <= S_DONE;
          end
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          state <= S_SLOT_RD;
          steps <= steps + 1'b1;
          spos  <= spos + SW'(1);
          if ((steps + 1'b1) == kk) state <= S_DONE;
          unique case (cmd_t'(cur.command))
            CMD_ADD_EDGE: begin
              if (!ram_rdata[EW-1]) begin
                reg_status <= ST_OK;
                fcnt       <= fcnt + CW'(1);
                state      <= S_DONE;
              end
            end
            CMD_REM_EDGE: begin
              if (hit_t && fcnt != '0) begin
                fcnt <= fcnt - CW'(1);
              end
            end
            CMD_CONNECTED: begin
              if (hit_t) reg_found <= 1'b1;
            end
            CMD_NEXT_NBR: begin
              spos    <= rot_nxt;
              if (ram_rdata[EW-1]) begin
                reg_found  <= 1'b1;
                reg_rv     <= ram_rdata[5:0];
                reg_status <= ST_OK;
                state      <= S_DONE;
              end else if ((steps + 1'b1) != kk) begin
                rot_ptr <= rot_nxt;
              end
            end
            default: ;
          endcase
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bounded_graph_adjacency_table.sv
// Top level: command port, configuration register and the adjacency sequencer.
// One command at a time: start is taken when busy is low and the result beat appears
// with done high for one cycle; it cannot be stalled. Add vertex searches the vertices
// from the search pointer; edge commands and next neighbour walk up to K slots of the
// subject vertex; remove vertex clears its own slots, then scans every slot for incoming
// edges. In the walks and the scan each slot is read, then checked or written, through
// the single port of the adjacency memory. After reset a clearing pass runs through the
// slot and count memories with busy high.
module bounded_graph_adjacency_table import bga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [3:0] slots_reg;

  assign pready = 1'b1;
  assign prdata = (32'(paddr) == REG_SLOTS) ? {28'd0, slots_reg} : 32'd0;

  // hold the slots-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_reg <= SLOTS_RESET;
    end else if (psel && penable && pwrite && 32'(paddr) == REG_SLOTS) begin
      slots_reg <= pwdata[3:0];
    end
  end

  bga_seq u_seq (
    .clk(clk), .rst(rst), .start(start), .req(req), .slots_cfg(slots_reg),
    .busy(busy), .done(done), .rsp(rsp)
  );
endmodule

### rtl/core/bga_checker.sv
// Port-level checker for the adjacency table, bound to the top level.
module bga_checker import bga_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);
  // a result beat only while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while idle");
  // accepted command keeps block busy next cycle
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accept not followed by busy");
  // result beat lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst) done |-> rsp.status <= ST_INCONS)
    else $error("bad status");
endmodule

bind bounded_graph_adjacency_table bga_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

### tb/bounded_graph_adjacency_table_test.sv
// Testbench for the bounded graph adjacency table: directed and random commands against a predictor.
module bounded_graph_adjacency_table_test;
  import bga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bounded_graph_adjacency_table dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // graph image kept by the predictor
  bit         present_img [Vertices];
  bit         slot_used [Vertices][EdgeSlots];
  logic [6:0] slot_target [Vertices][EdgeSlots];
  int         nbr_count [Vertices];
  int         search_ptr;
  int         rot_ptr;
  logic [3:0] slots_reg;

  rsp_t pending_rsp[$];
  int   error_count;
  bit   idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.found !== want.found)
          report($sformatf("found %0d, expected %0d", rsp.found, want.found));
        if (rsp.result_vertex !== want.result_vertex)
          report($sformatf("result_vertex %0d, expected %0d", rsp.result_vertex,
                           want.result_vertex));
        if (rsp.edge_count !== want.edge_count)
          report($sformatf("edge_count %0d, expected %0d", rsp.edge_count, want.edge_count));
      end
    end
  end

  function automatic int active_slots();
    if (slots_reg < 1) return 1;
    if (slots_reg > EdgeSlots) return EdgeSlots;
    return int'(slots_reg);
  endfunction

  function automatic void clear_graph();
    for (int v = 0; v < Vertices; v++) begin
      present_img[v] = 0;
      nbr_count[v] = 0;
      for (int s = 0; s < EdgeSlots; s++) begin
        slot_used[v][s] = 0;
        slot_target[v][s] = '0;
      end
    end
    search_ptr = 0;
    rot_ptr = EdgeSlots - 1;
    slots_reg = SLOTS_RESET;
  endfunction

  // range, then presence checks shared by edge commands
  function automatic logic [2:0] edge_status(int f, int t);
    if (f >= Vertices || t >= Vertices) return ST_RANGE;
    if (!present_img[f] || !present_img[t]) return ST_MISSING;
    return ST_OK;
  endfunction

  // apply one command to the graph image and return its result
  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int   f;
    int   t;
    int   k;
    bit   ok;
    f = r.from_vertex;
    t = r.to_vertex;
    k = active_slots();
    o = '0;
    o.status = ST_OK;
    case (cmd_t'(r.command))
      CMD_ADD_VERTEX: begin
        ok = 0;
        for (int i = 0; i < Vertices; i++) begin
          if (search_ptr >= Vertices) search_ptr = 0;
          if (!present_img[search_ptr]) begin
            ok = 1;
            break;
          end
          search_ptr++;
          if (search_ptr >= Vertices) search_ptr = 0;
        end
        if (ok) begin
          present_img[search_ptr] = 1;
          o.result_vertex = 6'(search_ptr);
        end else begin
          o.status = ST_FULL;
        end
      end
      CMD_REM_VERTEX: begin
        if (f >= Vertices) o.status = ST_RANGE;
        else if (!present_img[f]) o.status = ST_MISSING;
        else begin
          present_img[f] = 0;
          if (f < search_ptr) search_ptr = f;
          for (int s = 0; s < EdgeSlots; s++) slot_used[f][s] = 0;
          nbr_count[f] = 0;
          for (int v = 0; v < Vertices; v++)
            for (int s = 0; s < EdgeSlots; s++)
              if (slot_used[v][s] && slot_target[v][s] == f) begin
                slot_used[v][s] = 0;
                if (nbr_count[v] > 0) nbr_count[v]--;
              end
        end
      end
      CMD_ADD_EDGE: begin
        o.status = edge_status(f, t);
        if (o.status == ST_OK) begin
          o.status = ST_FULL;
          for (int s = 0; s < k; s++)
            if (!slot_used[f][s]) begin
              slot_used[f][s] = 1;
              slot_target[f][s] = 7'(t);
              nbr_count[f]++;
              o.status = ST_OK;
              break;
            end
        end
      end
      CMD_REM_EDGE: begin
        o.status = edge_status(f, t);
        if (o.status == ST_OK)
          for (int s = 0; s < k; s++)
            if (slot_used[f][s] && slot_target[f][s] == t) begin
              slot_used[f][s] = 0;
              if (nbr_count[f] > 0) nbr_count[f]--;
            end
      end
      CMD_CONNECTED: begin
        o.status = edge_status(f, t);
        if (o.status == ST_OK)
          for (int s = 0; s < k; s++)
            if (slot_used[f][s] && slot_target[f][s] == t) o.found = 1'b1;
      end
      CMD_NEXT_NBR: begin
        if (f >= Vertices) o.status = ST_RANGE;
        else if (nbr_count[f] != 0) begin
          o.status = ST_INCONS;
          for (int s = 0; s < k; s++) begin
            rot_ptr++;
            if (rot_ptr >= k) rot_ptr = 0;
            if (slot_used[f][rot_ptr]) begin
              o.found = 1'b1;
              o.result_vertex = slot_target[f][rot_ptr][5:0];
              o.status = ST_OK;
              break;
            end
          end
        end
      end
      CMD_EDGE_COUNT: begin
        if (f >= Vertices) o.status = ST_RANGE;
      end
      default: begin
        if (f >= Vertices) o.status = ST_RANGE;
        else o.found = present_img[f];
      end
    endcase
    o.edge_count = (f < Vertices) ? nbr_count[f][3:0] : 4'd0;
    return o;
  endfunction

  // hold start and the command until the block takes it
  task automatic send_command(input cmd_t c, input int f, input int t);
    req_t r;
    r.command = c;
    r.from_vertex = f[6:0];
    r.to_vertex = t[6:0];
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_command(r));
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_slots(input logic [3:0] value);
    wait_drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 1'(REG_SLOTS);
    pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    slots_reg = value;
    @(posedge clk);
  endtask

  function automatic int pick_vertex();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return $urandom_range(0, 11);
    if (sel < 18) return $urandom_range(0, Vertices - 1);
    return $urandom_range(0, 127);
  endfunction

  function automatic cmd_t pick_command();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 14) return CMD_ADD_VERTEX;
    if (sel < 18) return CMD_REM_VERTEX;
    if (sel < 44) return CMD_ADD_EDGE;
    if (sel < 54) return CMD_REM_EDGE;
    if (sel < 65) return CMD_CONNECTED;
    if (sel < 80) return CMD_NEXT_NBR;
    if (sel < 90) return CMD_EDGE_COUNT;
    return CMD_EXISTS;
  endfunction

  // extremes, every command and the range and missing cases
  task automatic test_directed();
    send_command(CMD_EXISTS, 127, 0);
    send_command(CMD_NEXT_NBR, 64, 0);
    send_command(CMD_REM_VERTEX, 0, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_ADD_EDGE, 0, 127);
    send_command(CMD_ADD_EDGE, 0, 5);
    send_command(CMD_ADD_EDGE, 0, 1);
    send_command(CMD_ADD_EDGE, 0, 1);
    send_command(CMD_ADD_EDGE, 2, 1);
    send_command(CMD_CONNECTED, 0, 1);
    send_command(CMD_NEXT_NBR, 0, 0);
    send_command(CMD_NEXT_NBR, 1, 0);
    send_command(CMD_EDGE_COUNT, 0, 0);
    send_command(CMD_REM_EDGE, 0, 1);
    send_command(CMD_CONNECTED, 0, 1);
    send_command(CMD_ADD_EDGE, 0, 1);
    send_command(CMD_REM_VERTEX, 1, 0);
    send_command(CMD_EDGE_COUNT, 0, 0);
    send_command(CMD_EDGE_COUNT, 2, 0);
    send_command(CMD_EXISTS, 1, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_REM_EDGE, 127, 0);
  endtask

  // fill one vertex, drop its edges to two targets, then narrow the slot window
  task automatic test_slot_window();
    write_slots(4'd8);
    for (int i = 0; i < 9; i++) send_command(CMD_ADD_EDGE, 2, i % 3);
    send_command(CMD_REM_EDGE, 2, 0);
    send_command(CMD_REM_EDGE, 2, 1);
    send_command(CMD_ADD_EDGE, 2, 0);
    send_command(CMD_REM_EDGE, 2, 0);
    write_slots(4'd2);
    send_command(CMD_NEXT_NBR, 2, 0);
    send_command(CMD_ADD_EDGE, 2, 1);
    send_command(CMD_NEXT_NBR, 2, 0);
    write_slots(4'd0);
    send_command(CMD_ADD_EDGE, 0, 2);
    send_command(CMD_NEXT_NBR, 0, 0);
  endtask

  // run the table to full and back
  task automatic test_table_full();
    for (int i = 0; i < Vertices + 2; i++) send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_REM_VERTEX, Vertices - 1, 0);
    send_command(CMD_REM_VERTEX, 7, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    send_command(CMD_ADD_VERTEX, 0, 0);
    for (int v = 12; v < Vertices; v++) send_command(CMD_REM_VERTEX, v, 0);
  endtask

  task automatic test_random(input logic [3:0] slots, input int count);
    cmd_t c;
    write_slots(slots);
    for (int i = 0; i < count; i++) begin
      c = pick_command();
      send_command(c, pick_vertex(), pick_vertex());
      sender_gap();
    end
  endtask

  initial begin
    logic [3:0] phase_slots [8];
    phase_slots = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8};
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    idle_on = 1'b1;
    clear_graph();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_slot_window();
    test_table_full();
    for (int p = 0; p < 8; p++) begin
      if (p == 7) idle_on = 1'b0;
      test_random(phase_slots[p], 120);
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bga_pkg.sv
rtl/core/bga_ram.sv
rtl/core/bga_seq.sv
rtl/core/bounded_graph_adjacency_table.sv
rtl/core/bga_checker.sv
tb/bounded_graph_adjacency_table_test.sv
